### rtl/fixed_pattern_match_line_column_top_assert.svh
// ----------------------------------------------------------------------------
// fixed_pattern_match_line_column_top_assert
// Assertion macros for the pattern match block.
// ----------------------------------------------------------------------------
// Each expects aclk and aresetn in the scope where it is used.
`ifndef FIXED_PATTERN_MATCH_LINE_COLUMN_TOP_ASSERT_SVH
`define FIXED_PATTERN_MATCH_LINE_COLUMN_TOP_ASSERT_SVH

// Consequent in the same cycle.
`define FPMLC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the next cycle.
`define FPMLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fpmlc_pkg.sv
// ----------------------------------------------------------------------------
// fpmlc_pkg
// Types and constants shared by the pattern match block.
// ----------------------------------------------------------------------------
package fpmlc_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int DATA_W          = 8;
    localparam int LINE_W          = 24;
    localparam int COL_W           = 20;
    localparam int TOTAL_W         = 24;
    localparam int LEN_W           = 6;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int PAT_WORDS       = 4;
    localparam int PAT_BYTES       = 32;
    localparam int PAT_BYTE_IDX_W  = 5;

    localparam logic [DATA_W-1:0]  NEWLINE   = 8'h0A;
    localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
    localparam logic [COL_W-1:0]   COL_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              byte_valid;
        logic              end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [LINE_W-1:0]  match_line;
        logic [COL_W-1:0]   match_column;
        logic               is_end;
        logic [TOTAL_W-1:0] match_total;
        logic               last;
    } result_t;

    // What one input word leaves for the output side
    typedef struct packed {
        logic               hit;
        logic               eof;
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   column;
        logic [TOTAL_W-1:0] total;
    } pair_t;

endpackage

### rtl/fpmlc_cfg.sv
// ----------------------------------------------------------------------------
// fpmlc_cfg
// Pattern registers, effective length and the pattern aligned to the window.
// ----------------------------------------------------------------------------
module fpmlc_cfg import fpmlc_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int CNT_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wr_data,
    output logic [CNT_W-1:0]          eff_len,
    output logic [PATTERN_MAX*8-1:0]  aligned_pat
);

    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] pat_word_reg [PAT_WORDS];
    logic [PAT_BYTES*8-1:0] pat_flat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg <= LEN_W'(1);
            for (int w = 0; w < PAT_WORDS; w++) begin
                pat_word_reg[w] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: pat_len_reg     <= cfg_wr_data[LEN_W-1:0];
                REG_PATTERN_WORD_0: pat_word_reg[0] <= cfg_wr_data;
                REG_PATTERN_WORD_1: pat_word_reg[1] <= cfg_wr_data;
                REG_PATTERN_WORD_2: pat_word_reg[2] <= cfg_wr_data;
                REG_PATTERN_WORD_3: pat_word_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign pat_flat = {pat_word_reg[3], pat_word_reg[2], pat_word_reg[1], pat_word_reg[0]};

    // Clamp the length to 1..PATTERN_MAX
    always_comb begin
        if (pat_len_reg == '0) begin
            eff_len = CNT_W'(1);
        end else if ({1'b0, pat_len_reg} > (LEN_W+1)'(PATTERN_MAX)) begin
            eff_len = CNT_W'(PATTERN_MAX);
        end else begin
            eff_len = CNT_W'(pat_len_reg);
        end
    end

    // Window entry i is compared with pattern byte eff_len-1-i
    always_comb begin
        logic [LEN_W:0] j;
        aligned_pat = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            j = (LEN_W+1)'(eff_len) - (LEN_W+1)'(i) - (LEN_W+1)'(1);
            if ((LEN_W+1)'(i) < (LEN_W+1)'(eff_len) && j < (LEN_W+1)'(PAT_BYTES)) begin
                aligned_pat[i*8 +: 8] = pat_flat[{j[PAT_BYTE_IDX_W-1:0], 3'b000} +: 8];
            end
        end
    end

endmodule

### rtl/fpmlc_core.sv
// ----------------------------------------------------------------------------
// fpmlc_core
// Byte window with positions, line and column counters, parallel compare.
// ----------------------------------------------------------------------------
module fpmlc_core import fpmlc_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int CNT_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  in_item_t                  item,
    input  logic [CNT_W-1:0]          eff_len,
    input  logic [PATTERN_MAX*8-1:0]  aligned_pat,
    output pair_t                     pair
);

    localparam int WIN_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [DATA_W-1:0] win_byte_reg [PATTERN_MAX];
    logic [LINE_W-1:0] win_line_reg [PATTERN_MAX];
    logic [COL_W-1:0]  win_col_reg  [PATTERN_MAX];
    logic [DATA_W-1:0] win_byte_next [PATTERN_MAX];
    logic [LINE_W-1:0] win_line_next [PATTERN_MAX];
    logic [COL_W-1:0]  win_col_next  [PATTERN_MAX];

    logic [CNT_W-1:0]   seen_reg, seen_next, seen_shift;
    logic [LINE_W-1:0]  line_reg, line_next, line_adv;
    logic [COL_W-1:0]   col_reg, col_next, col_adv;
    logic [TOTAL_W-1:0] count_reg, count_next, count_hit;
    logic [WIN_W-1:0]   sel_idx;
    logic               bytes_ok;
    logic               hit;

    // Shifted window with the new byte at entry 0
    always_comb begin
        win_byte_next[0] = item.data_byte;
        win_line_next[0] = line_reg;
        win_col_next[0]  = col_reg;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            win_byte_next[k] = win_byte_reg[k-1];
            win_line_next[k] = win_line_reg[k-1];
            win_col_next[k]  = win_col_reg[k-1];
        end
    end

    assign seen_shift = (seen_reg < CNT_W'(PATTERN_MAX)) ? seen_reg + CNT_W'(1) : seen_reg;

    always_comb begin
        if (item.data_byte == NEWLINE) begin
            line_adv = (line_reg != LINE_MAX) ? line_reg + LINE_W'(1) : line_reg;
            col_adv  = COL_W'(1);
        end else begin
            line_adv = line_reg;
            col_adv  = (col_reg != COL_MAX) ? col_reg + COL_W'(1) : col_reg;
        end
    end

    assign bytes_ok = seen_shift >= eff_len;
    assign sel_idx  = WIN_W'(eff_len - CNT_W'(1));

    always_comb begin
        hit = item.byte_valid && bytes_ok;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (CNT_W'(i) < eff_len && win_byte_next[i] != aligned_pat[i*8 +: 8]) begin
                hit = 1'b0;
            end
        end
    end

    assign count_hit = (hit && count_reg != TOTAL_MAX) ? count_reg + TOTAL_W'(1) : count_reg;

    always_comb begin
        pair.hit    = hit;
        pair.eof    = item.end_of_file;
        pair.line   = win_line_next[sel_idx];
        pair.column = win_col_next[sel_idx];
        pair.total  = count_hit;
    end

    // End of file returns the file state to its start
    always_comb begin
        if (item.end_of_file) begin
            seen_next  = '0;
            line_next  = LINE_W'(1);
            col_next   = COL_W'(1);
            count_next = '0;
        end else if (item.byte_valid) begin
            seen_next  = seen_shift;
            line_next  = line_adv;
            col_next   = col_adv;
            count_next = count_hit;
        end else begin
            seen_next  = seen_reg;
            line_next  = line_reg;
            col_next   = col_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            line_reg  <= LINE_W'(1);
            col_reg   <= COL_W'(1);
            count_reg <= '0;
        end else if (step) begin
            seen_reg  <= seen_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            count_reg <= count_next;
        end
    end

    // Entries beyond the bytes seen are never compared, so no reset
    always_ff @(posedge aclk) begin
        if (step && item.byte_valid) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                win_byte_reg[k] <= win_byte_next[k];
                win_line_reg[k] <= win_line_next[k];
                win_col_reg[k]  <= win_col_next[k];
            end
        end
    end

endmodule

### rtl/fpmlc_out.sv
// ----------------------------------------------------------------------------
// fpmlc_out
// Result register: sends the match word, then the end word, of one input.
// ----------------------------------------------------------------------------
module fpmlc_out import fpmlc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  pair_t   pair,
    output logic    free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic               occ_vld_reg;
    logic               end_vld_reg;
    logic [LINE_W-1:0]  line_reg;
    logic [COL_W-1:0]   col_reg;
    logic [TOTAL_W-1:0] total_reg;

    assign m_valid = occ_vld_reg | end_vld_reg;
    // Free when empty or when the final word goes this cycle
    assign free = !m_valid || (m_ready && (occ_vld_reg ^ end_vld_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_vld_reg <= 1'b0;
            end_vld_reg <= 1'b0;
        end else if (load) begin
            occ_vld_reg <= pair.hit;
            end_vld_reg <= pair.eof;
        end else if (m_valid && m_ready) begin
            if (occ_vld_reg) begin
                occ_vld_reg <= 1'b0;
            end else begin
                end_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            line_reg  <= pair.line;
            col_reg   <= pair.column;
            total_reg <= pair.total;
        end
    end

    always_comb begin
        m_data.match_total = total_reg;
        if (occ_vld_reg) begin
            m_data.match_line   = line_reg;
            m_data.match_column = col_reg;
            m_data.is_end       = 1'b0;
            m_data.last         = !end_vld_reg;
        end else begin
            m_data.match_line   = '0;
            m_data.match_column = '0;
            m_data.is_end       = 1'b1;
            m_data.last         = 1'b1;
        end
    end

endmodule

### rtl/fixed_pattern_match_line_column_top.sv
// Streaming search for a fixed pattern of 1 to PATTERN_MAX bytes, one file byte per
// input word, reporting line and column of the first byte of every occurrence
// (overlaps included) and an end word with the file's total at end of file. It
// takes one word per cycle while the result side is not stalled; a result passes
// through an input register, a combinational window compare and a result
// register. A byte that both completes a match and ends the file gives two
// result words, the match word first, and the input waits until the match word
// has left. No clearing pass is needed after reset.

// ----------------------------------------------------------------------------
// fixed_pattern_match_line_column_top
// Top level: input register, configuration, window compare, result register.
// ----------------------------------------------------------------------------
module fixed_pattern_match_line_column_top import fpmlc_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

`include "fixed_pattern_match_line_column_top_assert.svh"

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    in_item_t                 in_reg;
    logic                     in_vld_reg;
    logic                     out_free;
    logic                     advance;
    logic [CNT_W-1:0]         eff_len;
    logic [PATTERN_MAX*8-1:0] aligned_pat;
    pair_t                    pair;

    assign advance = in_vld_reg && out_free;
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    fpmlc_cfg #(
        .PATTERN_MAX (PATTERN_MAX),
        .CNT_W       (CNT_W)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .eff_len     (eff_len),
        .aligned_pat (aligned_pat)
    );

    fpmlc_core #(
        .PATTERN_MAX (PATTERN_MAX),
        .CNT_W       (CNT_W)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (in_reg),
        .eff_len     (eff_len),
        .aligned_pat (aligned_pat),
        .pair        (pair)
    );

    fpmlc_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .pair    (pair),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `FPMLC_ASSERT_SAME(a_no_advance_on_stall, m_valid && !m_ready, !advance,
        "input advanced while result stalled")
    `FPMLC_ASSERT_NEXT(a_eof_gives_result, advance && in_reg.end_of_file, m_valid,
        "end of file gave no result")
    `FPMLC_ASSERT_NEXT(a_empty_word_silent,
        advance && !in_reg.byte_valid && !in_reg.end_of_file, !m_valid,
        "empty word gave a result")

endmodule
